// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
// the including module must provide clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge out of reset
`define SSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never be seen out of reset
`define SSP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/ssp_pkg.sv =====
// shared types, constants and saturation helpers for the sprite projection pipe
// no dependencies
package ssp_pkg;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam int HALF_W        = SCREEN_WIDTH / 2;
    localparam int HALF_H        = SCREEN_HEIGHT / 2;
    localparam int FULL_NUM      = SCREEN_HEIGHT * 65536;

    // divider lane geometry
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_LAT   = DIV_Q_W;

    // register stages per unit
    localparam int XF_LAT    = 4;
    localparam int CAM_LAT   = DIV_LAT + 1;
    localparam int PROJ_LAT  = 2 * DIV_LAT + 4;
    localparam int BND_LAT   = 1;
    localparam int TOTAL_LAT = XF_LAT + CAM_LAT + PROJ_LAT + BND_LAT;

    typedef struct packed {
        logic signed [31:0] sprite_x;
        logic signed [31:0] sprite_y;
        logic signed [31:0] player_x;
        logic signed [31:0] player_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic signed [15:0] vertical_offset;
        logic [7:0]         height_divisor;
        logic [7:0]         width_divisor;
    } sprite_in_t;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] depth;
        logic signed [15:0] screen_column;
        logic signed [15:0] vertical_shift;
        logic [14:0]        sprite_height;
        logic [14:0]        sprite_width;
        logic [14:0]        start_row;
        logic signed [15:0] end_row;
        logic [14:0]        start_column;
        logic signed [15:0] end_column;
    } sprite_out_t;

    typedef struct packed {
        logic signed [15:0] voff;
        logic [7:0]         hdiv;
        logic [7:0]         wdiv;
    } tail_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num_tx;
        logic [DIV_NUM_W-1:0] num_ty;
        logic [DIV_DEN_W-1:0] den;
        logic                 det_zero;
        logic                 neg_tx;
        logic                 neg_ty;
        tail_t                tail;
    } xf_word_t;

    typedef struct packed {
        logic  det_zero;
        logic  neg_tx;
        logic  neg_ty;
        tail_t tail;
    } cam_side_t;

    typedef struct packed {
        logic               det_zero;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        tail_t              tail;
    } cam_word_t;

    typedef struct packed {
        logic               vis;
        logic               det_zero;
        logic signed [31:0] ty;
        logic               neg_sh;
        logic               neg_col;
        logic [7:0]         hd;
        logic [7:0]         wd;
    } pa_side_t;

    typedef struct packed {
        logic               vis;
        logic               det_zero;
        logic signed [31:0] ty;
        logic signed [15:0] shift;
        logic signed [15:0] col;
    } pb_side_t;

    typedef struct packed {
        logic               vis;
        logic               det_zero;
        logic signed [31:0] ty;
        logic signed [15:0] shift;
        logic signed [15:0] col;
        logic [14:0]        hgt;
        logic [14:0]        wid;
    } proj_word_t;

    // signed 32 bit result from quotient magnitude, overflow and sign
    function automatic logic signed [31:0] sat_s32(input logic [DIV_Q_W-1:0] mag,
                                                   input logic ovf, input logic neg);
        logic [31:0] res;
        if (neg)
        begin
            if (ovf || mag[32] || (mag[31] && (|mag[30:0])))
                res = 32'h8000_0000;
            else
                res = ~mag[31:0] + 32'd1;
        end
        else
        begin
            if (ovf || mag[32] || mag[31])
                res = 32'h7FFF_FFFF;
            else
                res = mag[31:0];
        end
        return $signed(res);
    endfunction

    // signed 16 bit result from quotient magnitude, overflow and sign
    function automatic logic signed [15:0] sat_s16(input logic [DIV_Q_W-1:0] mag,
                                                   input logic ovf, input logic neg);
        logic [15:0] res;
        if (neg)
        begin
            if (ovf || (|mag[32:16]) || (mag[15] && (|mag[14:0])))
                res = 16'h8000;
            else
                res = ~mag[15:0] + 16'd1;
        end
        else
        begin
            if (ovf || (|mag[32:15]))
                res = 16'h7FFF;
            else
                res = mag[15:0];
        end
        return $signed(res);
    endfunction

    // unsigned 15 bit result from quotient magnitude
    function automatic logic [14:0] sat_u15(input logic [DIV_Q_W-1:0] mag, input logic ovf);
        return (ovf || (|mag[32:15])) ? 15'h7FFF : mag[14:0];
    endfunction

endpackage

// ===== src/sprite_screen_projection.sv =====
// top level of the sprite screen projection pipeline
// depends on ssp_pkg, ssp_xform, ssp_cam_div, ssp_proj_div, ssp_bounds, assert_macros.svh
//
//  channel  dir  handshake      word
//  query    in   start / busy   sprite_in_t, taken when start is high and busy low
//  result   out  done           sprite_out_t, valid for the one cycle done is high
//
//  one word is taken every cycle; busy is never raised
//  each result's delay after its query is set by the register count of
//  the pipe: 4 front stages, 33 + 1 for the camera divide, 70 for the projection
//  divides (two chained 33 stage divider lanes), 1 for the bounds register
//  reset clears only the valid bits along the pipe, data registers are not reset
//  results cannot be held off, so nothing in the pipe ever stalls
`include "assert_macros.svh"

module sprite_screen_projection (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ssp_pkg::sprite_in_t  query,
    output logic                 done,
    output ssp_pkg::sprite_out_t result
);
    import ssp_pkg::*;

    logic       accept;
    logic       xf_valid, cam_valid, proj_valid;
    xf_word_t   xf;
    cam_word_t  cam;
    proj_word_t proj;

    // the pipe advances every cycle, so a query is always welcome
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // relative position, determinant and the two camera numerators
    ssp_xform u_xform (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (accept),
        .item       (query),
        .xf_valid   (xf_valid),
        .xf         (xf)
    );

    // tx and ty, the camera space position, saturated to q16.16
    ssp_cam_div u_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .xf_valid  (xf_valid),
        .xf        (xf),
        .cam_valid (cam_valid),
        .cam       (cam)
    );

    // shift, column and full height by depth, then height and width by divisors
    ssp_proj_div u_proj (
        .clk        (clk),
        .rst_n      (rst_n),
        .cam_valid  (cam_valid),
        .cam        (cam),
        .proj_valid (proj_valid),
        .proj       (proj)
    );

    // row and column bounds clamped to the screen, result register
    ssp_bounds u_bounds (
        .clk        (clk),
        .rst_n      (rst_n),
        .proj_valid (proj_valid),
        .proj       (proj),
        .done       (done),
        .result     (result)
    );

    // every result traces back to a query a fixed latency earlier
    `SSP_ASSERT_IMP(a_latency, done, $past(start, TOTAL_LAT), "result without query")
    // a visible sprite always lies in front of the camera
    `SSP_ASSERT_IMP(a_vis_depth, done && result.visible, result.depth > 0, "visible at depth <= 0")
    // hidden sprites carry no size or bounds
    `SSP_ASSERT_IMP(a_hidden_zero, done && !result.visible,
                    result.sprite_height == '0 && result.start_column == '0,
                    "hidden sprite with size")
    // right bound never passes the screen edge
    `SSP_ASSERT_NEVER(a_col_bound, done && (result.end_column > SCREEN_WIDTH - 1),
                      "end column beyond screen")

endmodule

// ===== src/ssp_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on ssp_pkg
module ssp_div_lane (
    input  logic                          clk,
    input  logic [ssp_pkg::DIV_NUM_W-1:0] num,
    input  logic [ssp_pkg::DIV_DEN_W-1:0] den,
    output logic [ssp_pkg::DIV_Q_W-1:0]   quo,
    output logic                          ovf
);
    import ssp_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg [DIV_LAT-1];
    logic [DIV_Q_W-1:0]   nlo_reg [DIV_LAT-1];
    logic [DIV_DEN_W-1:0] den_reg [DIV_LAT-1];
    logic [DIV_Q_W-1:0]   quo_reg [DIV_LAT];
    logic                 ovf_reg [DIV_LAT];

    generate
        for (genvar i = 0; i < DIV_LAT; i++)
        begin : g_step
            logic [DIV_DEN_W-1:0] r_in;
            logic [DIV_DEN_W-1:0] d_in;
            logic [DIV_Q_W-1:0]   n_in;
            logic [DIV_Q_W-1:0]   q_in;
            logic                 o_in;
            logic [DIV_DEN_W:0]   trial;
            logic [DIV_DEN_W:0]   diff;
            logic                 take;

            if (i == 0)
            begin : g_first
                // quotient must fit the lane, else flag overflow
                assign r_in = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
                assign n_in = num[DIV_Q_W-1:0];
                assign q_in = '0;
                assign d_in = den;
                assign o_in = (DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den);
            end
            else
            begin : g_next
                assign r_in = rem_reg[i-1];
                assign n_in = nlo_reg[i-1];
                assign q_in = quo_reg[i-1];
                assign d_in = den_reg[i-1];
                assign o_in = ovf_reg[i-1];
            end

            assign trial = {r_in, n_in[DIV_Q_W-1-i]};
            assign diff  = trial - {1'b0, d_in};
            assign take  = (trial >= {1'b0, d_in});

            always_ff @(posedge clk)
            begin
                quo_reg[i] <= {q_in[DIV_Q_W-2:0], take};
                ovf_reg[i] <= o_in;
            end

            if (i < DIV_LAT - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[i] <= take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                    nlo_reg[i] <= n_in;
                    den_reg[i] <= d_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_LAT-1];
    assign ovf = ovf_reg[DIV_LAT-1];

endmodule

// ===== src/ssp_xform.sv =====
// front end: relative position, determinant and camera numerators, four stages
// depends on ssp_pkg
module ssp_xform (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  ssp_pkg::sprite_in_t item,
    output logic                xf_valid,
    output ssp_pkg::xf_word_t   xf
);
    import ssp_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [31:0] pd1_reg, pd2_reg;
    logic signed [15:0] dirx1_reg, diry1_reg, plx1_reg, ply1_reg;
    tail_t              tail1_reg;

    // stage 2
    logic signed [32:0] det2_reg;
    logic signed [48:0] m1_reg, m2_reg, m3_reg, m4_reg;
    tail_t              tail2_reg;

    // stage 3
    logic signed [32:0] det3_reg;
    logic signed [49:0] ntx3_reg, nty3_reg;
    tail_t              tail3_reg;

    // stage 4
    xf_word_t           xf_reg, xf_next;
    logic [49:0]        abs_tx, abs_ty;
    logic [32:0]        abs_det;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg   <= {item.sprite_x[31], item.sprite_x} - {item.player_x[31], item.player_x};
        dy1_reg   <= {item.sprite_y[31], item.sprite_y} - {item.player_y[31], item.player_y};
        pd1_reg   <= item.plane_x * item.dir_y;
        pd2_reg   <= item.dir_x * item.plane_y;
        dirx1_reg <= item.dir_x;
        diry1_reg <= item.dir_y;
        plx1_reg  <= item.plane_x;
        ply1_reg  <= item.plane_y;
        tail1_reg <= '{voff: item.vertical_offset, hdiv: item.height_divisor,
                       wdiv: item.width_divisor};

        det2_reg  <= {pd1_reg[31], pd1_reg} - {pd2_reg[31], pd2_reg};
        m1_reg    <= diry1_reg * dx1_reg;
        m2_reg    <= dirx1_reg * dy1_reg;
        m3_reg    <= plx1_reg * dy1_reg;
        m4_reg    <= ply1_reg * dx1_reg;
        tail2_reg <= tail1_reg;

        det3_reg  <= det2_reg;
        ntx3_reg  <= {m1_reg[48], m1_reg} - {m2_reg[48], m2_reg};
        nty3_reg  <= {m3_reg[48], m3_reg} - {m4_reg[48], m4_reg};
        tail3_reg <= tail2_reg;

        xf_reg    <= xf_next;
    end

    // magnitudes and signs for the unsigned divider lanes
    always_comb
    begin
        abs_tx  = ntx3_reg[49] ? (~ntx3_reg + 50'd1) : ntx3_reg;
        abs_ty  = nty3_reg[49] ? (~nty3_reg + 50'd1) : nty3_reg;
        abs_det = det3_reg[32] ? (~det3_reg + 33'd1) : det3_reg;
        xf_next.num_tx   = {abs_tx, 14'b0};
        xf_next.num_ty   = {abs_ty, 14'b0};
        xf_next.den      = abs_det[31:0];
        xf_next.det_zero = (det3_reg == '0);
        xf_next.neg_tx   = ntx3_reg[49] ^ det3_reg[32];
        xf_next.neg_ty   = nty3_reg[49] ^ det3_reg[32];
        xf_next.tail     = tail3_reg;
    end

    assign xf_valid = v4_reg;
    assign xf       = xf_reg;

endmodule

// ===== src/ssp_cam_div.sv =====
// camera transform divide: tx and ty lanes sharing the determinant
// depends on ssp_pkg, ssp_div_lane
module ssp_cam_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               xf_valid,
    input  ssp_pkg::xf_word_t  xf,
    output logic               cam_valid,
    output ssp_pkg::cam_word_t cam
);
    import ssp_pkg::*;

    logic [DIV_Q_W-1:0] tx_quo, ty_quo;
    logic               tx_ovf, ty_ovf;
    logic [DIV_LAT-1:0] vld_reg;
    cam_side_t          side_reg [DIV_LAT];
    logic               cam_valid_reg;
    cam_word_t          cam_reg;

    ssp_div_lane u_tx (
        .clk (clk),
        .num (xf.num_tx),
        .den (xf.den),
        .quo (tx_quo),
        .ovf (tx_ovf)
    );

    ssp_div_lane u_ty (
        .clk (clk),
        .num (xf.num_ty),
        .den (xf.den),
        .quo (ty_quo),
        .ovf (ty_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            cam_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[DIV_LAT-2:0], xf_valid};
            cam_valid_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{det_zero: xf.det_zero, neg_tx: xf.neg_tx, neg_ty: xf.neg_ty,
                         tail: xf.tail};
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        cam_reg.det_zero <= side_reg[DIV_LAT-1].det_zero;
        cam_reg.tx       <= sat_s32(tx_quo, tx_ovf, side_reg[DIV_LAT-1].neg_tx);
        cam_reg.ty       <= sat_s32(ty_quo, ty_ovf, side_reg[DIV_LAT-1].neg_ty);
        cam_reg.tail     <= side_reg[DIV_LAT-1].tail;
    end

    assign cam_valid = cam_valid_reg;
    assign cam       = cam_reg;

endmodule

// ===== src/ssp_proj_div.sv =====
// screen projection: divides by depth, then by the size divisors
// depends on ssp_pkg, ssp_div_lane
module ssp_proj_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cam_valid,
    input  ssp_pkg::cam_word_t  cam,
    output logic                proj_valid,
    output ssp_pkg::proj_word_t proj
);
    import ssp_pkg::*;

    // stage p0
    logic                 v0_reg;
    logic signed [32:0]   s0_reg;
    logic                 vis0_reg, dz0_reg;
    logic signed [31:0]   ty0_reg;
    tail_t                tail0_reg;

    // stage p1, lane inputs
    logic                 v1_reg;
    logic [DIV_NUM_W-1:0] num_sh1_reg, num_col1_reg;
    logic [DIV_DEN_W-1:0] den1_reg;
    pa_side_t             pa1_reg;
    logic [32:0]          abs_s;
    logic [16:0]          abs_v;

    logic [DIV_Q_W-1:0]   sh_quo, col_quo, full_quo, h_quo, w_quo;
    logic                 sh_ovf, col_ovf, full_ovf, h_ovf, w_ovf;

    logic [DIV_LAT-1:0]   vlda_reg, vldb_reg;
    pa_side_t             pa_reg [DIV_LAT];
    pb_side_t             pb_reg [DIV_LAT];

    // stage q1
    logic                 vq1_reg;
    logic [DIV_Q_W-1:0]   full_q_reg;
    logic [7:0]           hd_reg, wd_reg;
    pb_side_t             pbq_reg;

    // stage q2
    logic                 vq2_reg;
    proj_word_t           proj_reg;

    always_comb
    begin
        abs_s = s0_reg[32] ? (~s0_reg + 33'd1) : s0_reg;
        abs_v = tail0_reg.voff[15] ? (~{1'b1, tail0_reg.voff} + 17'd1)
                                   : {1'b0, tail0_reg.voff};
    end

    ssp_div_lane u_shift (
        .clk (clk),
        .num (num_sh1_reg),
        .den (den1_reg),
        .quo (sh_quo),
        .ovf (sh_ovf)
    );

    ssp_div_lane u_col (
        .clk (clk),
        .num (num_col1_reg),
        .den (den1_reg),
        .quo (col_quo),
        .ovf (col_ovf)
    );

    ssp_div_lane u_full (
        .clk (clk),
        .num (DIV_NUM_W'(FULL_NUM)),
        .den (den1_reg),
        .quo (full_quo),
        .ovf (full_ovf)
    );

    ssp_div_lane u_hgt (
        .clk (clk),
        .num (DIV_NUM_W'(full_q_reg)),
        .den (DIV_DEN_W'(hd_reg)),
        .quo (h_quo),
        .ovf (h_ovf)
    );

    ssp_div_lane u_wid (
        .clk (clk),
        .num (DIV_NUM_W'(full_q_reg)),
        .den (DIV_DEN_W'(wd_reg)),
        .quo (w_quo),
        .ovf (w_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            vlda_reg <= '0;
            vq1_reg  <= 1'b0;
            vldb_reg <= '0;
            vq2_reg  <= 1'b0;
        end
        else
        begin
            v0_reg   <= cam_valid;
            v1_reg   <= v0_reg;
            vlda_reg <= {vlda_reg[DIV_LAT-2:0], v1_reg};
            vq1_reg  <= vlda_reg[DIV_LAT-1];
            vldb_reg <= {vldb_reg[DIV_LAT-2:0], vq1_reg};
            vq2_reg  <= vldb_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        // p0: sum for the column and the visibility test
        s0_reg    <= {cam.tx[31], cam.tx} + {cam.ty[31], cam.ty};
        vis0_reg  <= !cam.det_zero && !cam.ty[31] && (cam.ty != '0);
        dz0_reg   <= cam.det_zero;
        ty0_reg   <= cam.ty;
        tail0_reg <= cam.tail;

        // p1: numerators and divisors, a zero size divisor acts as one
        num_sh1_reg  <= DIV_NUM_W'(abs_v) << 16;
        num_col1_reg <= DIV_NUM_W'(abs_s) * DIV_NUM_W'(HALF_W);
        den1_reg     <= ty0_reg[31:0];
        pa1_reg      <= '{vis: vis0_reg, det_zero: dz0_reg, ty: ty0_reg,
                          neg_sh: tail0_reg.voff[15], neg_col: s0_reg[32],
                          hd: (tail0_reg.hdiv == 8'd0) ? 8'd1 : tail0_reg.hdiv,
                          wd: (tail0_reg.wdiv == 8'd0) ? 8'd1 : tail0_reg.wdiv};

        pa_reg[0] <= pa1_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            pa_reg[i] <= pa_reg[i-1];
        end

        // q1: saturate shift and column, full height feeds the size lanes
        full_q_reg    <= full_ovf ? '1 : full_quo;
        hd_reg        <= pa_reg[DIV_LAT-1].hd;
        wd_reg        <= pa_reg[DIV_LAT-1].wd;
        pbq_reg.vis      <= pa_reg[DIV_LAT-1].vis;
        pbq_reg.det_zero <= pa_reg[DIV_LAT-1].det_zero;
        pbq_reg.ty       <= pa_reg[DIV_LAT-1].ty;
        pbq_reg.shift    <= sat_s16(sh_quo, sh_ovf, pa_reg[DIV_LAT-1].neg_sh);
        pbq_reg.col      <= sat_s16(col_quo, col_ovf, pa_reg[DIV_LAT-1].neg_col);

        pb_reg[0] <= pbq_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            pb_reg[i] <= pb_reg[i-1];
        end

        // q2: clamp height and width
        proj_reg.vis      <= pb_reg[DIV_LAT-1].vis;
        proj_reg.det_zero <= pb_reg[DIV_LAT-1].det_zero;
        proj_reg.ty       <= pb_reg[DIV_LAT-1].ty;
        proj_reg.shift    <= pb_reg[DIV_LAT-1].shift;
        proj_reg.col      <= pb_reg[DIV_LAT-1].col;
        proj_reg.hgt      <= sat_u15(h_quo, h_ovf);
        proj_reg.wid      <= sat_u15(w_quo, w_ovf);
    end

    assign proj_valid = vq2_reg;
    assign proj       = proj_reg;

endmodule

// ===== src/ssp_bounds.sv =====
// draw bounds, screen clamping and the result register
// depends on ssp_pkg
module ssp_bounds (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 proj_valid,
    input  ssp_pkg::proj_word_t  proj,
    output logic                 done,
    output ssp_pkg::sprite_out_t result
);
    import ssp_pkg::*;

    logic               done_reg;
    sprite_out_t        result_reg, result_next;
    logic signed [17:0] srow_s, erow_s, scol_s, ecol_s;

    always_comb
    begin
        srow_s = 18'(HALF_H) + 18'(proj.shift) - $signed({4'b0, proj.hgt[14:1]});
        erow_s = 18'(HALF_H) + 18'(proj.shift) + $signed({4'b0, proj.hgt[14:1]});
        scol_s = 18'(proj.col) - $signed({4'b0, proj.wid[14:1]});
        ecol_s = 18'(proj.col) + $signed({4'b0, proj.wid[14:1]});

        if (erow_s >= 18'(SCREEN_HEIGHT))
            erow_s = 18'(SCREEN_HEIGHT - 1);
        if (ecol_s >= 18'(SCREEN_WIDTH))
            ecol_s = 18'(SCREEN_WIDTH - 1);

        result_next = '0;
        result_next.depth = proj.det_zero ? '0 : proj.ty;
        if (proj.vis)
        begin
            result_next.visible        = 1'b1;
            result_next.screen_column  = proj.col;
            result_next.vertical_shift = proj.shift;
            result_next.sprite_height  = proj.hgt;
            result_next.sprite_width   = proj.wid;
            result_next.start_row      = (srow_s < 0) ? 15'd0
                                       : (srow_s > 18'sd32767) ? 15'h7FFF : srow_s[14:0];
            result_next.end_row        = (erow_s < -18'sd32768) ? 16'sh8000
                                                                : erow_s[15:0];
            result_next.start_column   = (scol_s < 0) ? 15'd0
                                       : (scol_s > 18'sd32767) ? 15'h7FFF : scol_s[14:0];
            result_next.end_column     = (ecol_s < -18'sd32768) ? 16'sh8000
                                                                : ecol_s[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= proj_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
